// ===== design/assert_macros.svh =====
// Assertion macros shared by the queue event step RTL.
// No dependencies; define NO_ASSERTIONS to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// The condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error(msg);

// When the antecedent holds, the consequent holds in the same cycle.
`define ASSERT_IMPLY(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error(msg);

// When the antecedent holds, the consequent holds in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error(msg);

`else

`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg)
`define ASSERT_IMPLY(label, clk, rst_n, pre, post, msg)
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg)

`endif

`endif

// ===== design/ssq_pkg.sv =====
// Types, constants and draw tables for the single-server queue event step.
// No dependencies; imported by the top level.
package ssq_pkg;

	// Configuration port.
	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = 32;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_QUEUE_LIMIT = 1'b0,
		REG_STOP_TIME   = 1'b1
	} cfg_reg_t;

	localparam int QLIM_W = 8;
	localparam int STOP_W = 32;
	localparam logic [QLIM_W-1:0] QLIMIT_RESET = 8'd100;
	localparam logic [STOP_W-1:0] STOP_RESET   = 32'd300;

	// Input word fields.
	localparam int RAND_W     = 16;
	localparam int IN_TDATA_W = 2 * RAND_W;
	localparam int IN_TUSER_W = 1;

	typedef enum logic {
		MODE_START = 1'b0,
		MODE_STEP  = 1'b1
	} mode_t;

	// Output word fields.
	localparam int NOW_W       = 32;
	localparam int QLEN_W      = 8;
	localparam int COUNT_W     = 32;
	localparam int DELAY_W     = 40;
	localparam int AREA_W      = 48;
	localparam int OUT_FIELD_W = NOW_W + QLEN_W + 1 + COUNT_W + DELAY_W + 2 * AREA_W + 2;
	localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
	localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;
	localparam int OUT_TUSER_W = 1;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
	localparam logic [DELAY_W-1:0] DELAY_MAX = '1;
	localparam logic [AREA_W-1:0]  AREA_MAX  = '1;

	typedef enum logic {
		EV_ARRIVAL   = 1'b0,
		EV_DEPARTURE = 1'b1
	} event_kind_t;

	// Drawn times fit in six bits.
	localparam int DRAW_W = 6;

	// Empirical interarrival table indexed by a 16-bit fraction.
	function automatic logic [DRAW_W-1:0] draw_arrival(input logic [RAND_W-1:0] k);
		logic [DRAW_W-1:0] v;
		priority if (k <= 16'd3276) begin
			v = 6'd5;
		end else if (k <= 16'd6553) begin
			v = 6'd10;
		end else if (k <= 16'd13107) begin
			v = 6'd15;
		end else if (k <= 16'd19660) begin
			v = 6'd20;
		end else if (k <= 16'd39321) begin
			v = 6'd25;
		end else if (k <= 16'd52428) begin
			v = 6'd30;
		end else if (k <= 16'd62259) begin
			v = 6'd35;
		end else begin
			v = 6'd40;
		end
		return v;
	endfunction

	// Empirical service time table indexed by a 16-bit fraction.
	function automatic logic [DRAW_W-1:0] draw_service(input logic [RAND_W-1:0] k);
		logic [DRAW_W-1:0] v;
		priority if (k <= 16'd9830) begin
			v = 6'd10;
		end else if (k <= 16'd26214) begin
			v = 6'd20;
		end else if (k <= 16'd52428) begin
			v = 6'd30;
		end else begin
			v = 6'd40;
		end
		return v;
	endfunction

endpackage

// ===== design/ssq_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies; holds the arrival-time queue of the event step block.
module ssq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port, data valid in the cycle after the enable.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== design/single_server_queue_event_step.sv =====
// Single-server queue, one discrete event per input word.
// A result passes through stages 1, 2 and 3 and the output register, which stall on the output.
// A new word is taken only once stage 1 has passed the previous one on; the arrival-time queue read is issued
// when a word is accepted and needs the head pointer left by the previous word.
// Reset (arst_n, asynchronous): simulation state cleared, queue_limit 100,
// stop_time 300; the queue memory is not cleared and needs no clearing pass.
`include "assert_macros.svh"

module single_server_queue_event_step #(
	parameter int FIFO_DEPTH = 128,
	parameter int TIME_WIDTH = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [ssq_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [ssq_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// rand_arrival [15:0], rand_service [31:16]
	input  logic [ssq_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
	// mode [0]
	input  logic [ssq_pkg::IN_TUSER_W-1:0]   s_axis_tuser,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// now_time [31:0], queue_length [39:32], busy_res [40], delayed_customers [72:41],
	// total_delay [112:73], queue_area [160:113], busy_area [208:161], overflow [209],
	// time_up [210], zero fill [215:211]
	output logic [ssq_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
	// event_kind [0]
	output logic [ssq_pkg::OUT_TUSER_W-1:0]  m_axis_tuser
);

	import ssq_pkg::*;

	localparam int TW         = TIME_WIDTH;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);
	localparam int WC_W       = $clog2(FIFO_DEPTH + 1);
	localparam int CMP_W      = (WC_W > QLIM_W) ? WC_W : QLIM_W;
	localparam int TU_W       = (TW > STOP_W) ? TW : STOP_W;
	localparam int PROD_W     = TW + WC_W;
	localparam int AREA_SUM_W = ((PROD_W > AREA_W) ? PROD_W : AREA_W) + 1;
	localparam int BUSY_SUM_W = ((TW > AREA_W) ? TW : AREA_W) + 1;
	localparam int DLY_SUM_W  = ((TW > DELAY_W) ? TW : DELAY_W) + 1;

	// Stage 2 carries the event result and what the accumulators need.
	typedef struct packed {
		event_kind_t         kind;
		logic [TW-1:0]       clock;
		logic [WC_W-1:0]     wc;
		logic                busy;
		logic [COUNT_W-1:0]  served;
		logic                ovf;
		logic                clear;
		logic [TW-1:0]       dt;
		logic [WC_W-1:0]     wc_old;
		logic                busy_old;
		logic                pop;
		logic [TW-1:0]       pop_diff;
	} s2_t;

	// Stage 3 carries the area increments and the finished scalar fields.
	typedef struct packed {
		event_kind_t         kind;
		logic [TW-1:0]       clock;
		logic [WC_W-1:0]     wc;
		logic                busy;
		logic [COUNT_W-1:0]  served;
		logic [DELAY_W-1:0]  delay;
		logic                ovf;
		logic                time_up;
		logic                clear;
		logic [PROD_W-1:0]   prod;
		logic [TW-1:0]       busy_dt;
	} s3_t;

	// Saturating add of a drawn time to a time value.
	function automatic logic [TW-1:0] sat_time(input logic [TW-1:0] base,
			input logic [DRAW_W-1:0] step);
		logic [TW:0] sum;
		sum = {1'b0, base} + (TW + 1)'(step);
		return sum[TW] ? {TW{1'b1}} : sum[TW-1:0];
	endfunction

	// Circular pointer advance for any depth.
	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(FIFO_DEPTH - 1)) ? {PTR_W{1'b0}} : p + 1'b1;
	endfunction

	// Configuration registers.
	logic [QLIM_W-1:0] qlimit_q;
	logic [STOP_W-1:0] stop_q;

	// Simulation state.
	logic [TW-1:0]      clock_q, next_arr_q, next_dep_q;
	logic               pend_q, server_q, ovf_q;
	logic [WC_W-1:0]    wc_q;
	logic [PTR_W-1:0]   head_q, tail_q;
	logic [COUNT_W-1:0] served_q;
	logic [DELAY_W-1:0] delay_q;
	logic [AREA_W-1:0]  len_area_q, busy_area_q;

	// Pipeline control and payload.
	logic               s1_valid_q, s2_valid_q, s3_valid_q, out_valid_q;
	logic               mode_s1;
	logic [RAND_W-1:0]  ra_s1, rs_s1;
	s2_t                st_s2, s2_n;
	s3_t                st_s3, s3_n;
	logic [OUT_TDATA_W-1:0] out_data_q, out_data_n;
	event_kind_t        out_kind_q;

	logic in_acc, s1_adv, s2_adv, out_load;
	logic [TW-1:0] head_time;

	// Next-state values from the event logic.
	logic [TW-1:0]      clock_n, next_arr_n, next_dep_n;
	logic               pend_n, server_n, ovf_n, push;
	logic [WC_W-1:0]    wc_n;
	logic [PTR_W-1:0]   head_n, tail_n;
	logic [COUNT_W-1:0] served_n;
	logic [DELAY_W-1:0] delay_n;
	logic [AREA_W-1:0]  len_area_n, busy_area_n;

	// Handshake: one word in stage 1 at a time, later stages stall on the output.
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = !s1_valid_q;
	assign out_load      = s3_valid_q && (!out_valid_q || m_axis_tready);
	assign s2_adv        = s2_valid_q && (!s3_valid_q || out_load);
	assign s1_adv        = s1_valid_q && (!s2_valid_q || s2_adv);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			s2_valid_q  <= 1'b0;
			s3_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			s1_valid_q  <= in_acc || (s1_valid_q && !s1_adv);
			s2_valid_q  <= s1_adv || (s2_valid_q && !s2_adv);
			s3_valid_q  <= s2_adv || (s3_valid_q && !out_load);
			out_valid_q <= out_load || (out_valid_q && !m_axis_tready);
		end
	end

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qlimit_q <= QLIMIT_RESET;
			stop_q   <= STOP_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_QUEUE_LIMIT: qlimit_q <= cfg_wdata[QLIM_W-1:0];
				REG_STOP_TIME:   stop_q   <= cfg_wdata[STOP_W-1:0];
			endcase
		end
	end

	// Stage 1 input word.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			mode_s1 <= s_axis_tuser[0];
			ra_s1   <= s_axis_tdata[RAND_W-1:0];
			rs_s1   <= s_axis_tdata[2*RAND_W-1:RAND_W];
		end
	end

	// Arrival-time queue; the head entry is read as a word is accepted.
	ssq_ram #(
		.WIDTH(TW),
		.DEPTH(FIFO_DEPTH)
	) u_fifo_ram (
		.clk  (clk),
		.we   (s1_adv && push),
		.waddr(tail_q),
		.wdata(next_arr_q),
		.re   (in_acc),
		.raddr(head_q),
		.rdata(head_time)
	);

	// Stage 1: clear on a start word, else pick the event, advance the clock and update the queue.
	always_comb begin
		logic              is_dep, full;
		logic [TW-1:0]     dt_arr, dt_dep, pop_diff;
		logic [DRAW_W-1:0] ia, sv;
		logic [COUNT_W-1:0] served_inc;

		is_dep     = pend_q && (next_dep_q <= next_arr_q);
		dt_arr     = (next_arr_q >= clock_q) ? next_arr_q - clock_q : {TW{1'b0}};
		dt_dep     = (next_dep_q >= clock_q) ? next_dep_q - clock_q : {TW{1'b0}};
		pop_diff   = (next_dep_q >= head_time) ? next_dep_q - head_time : {TW{1'b0}};
		ia         = draw_arrival(ra_s1);
		sv         = draw_service(rs_s1);
		full       = (CMP_W'(wc_q) >= CMP_W'(qlimit_q)) || (wc_q == WC_W'(FIFO_DEPTH));
		served_inc = (served_q == COUNT_MAX) ? served_q : served_q + 1'b1;

		clock_n    = clock_q;
		next_arr_n = next_arr_q;
		next_dep_n = next_dep_q;
		pend_n     = pend_q;
		server_n   = server_q;
		ovf_n      = ovf_q;
		wc_n       = wc_q;
		head_n     = head_q;
		tail_n     = tail_q;
		served_n   = served_q;
		push       = 1'b0;

		s2_n          = '0;
		s2_n.kind     = EV_ARRIVAL;
		s2_n.wc_old   = wc_q;
		s2_n.busy_old = server_q;
		s2_n.pop_diff = pop_diff;

		if (mode_s1 == MODE_START) begin
			// Start: clear everything and schedule the first arrival.
			clock_n    = '0;
			next_arr_n = TW'(ia);
			next_dep_n = '0;
			pend_n     = 1'b0;
			server_n   = 1'b0;
			ovf_n      = 1'b0;
			wc_n       = '0;
			head_n     = '0;
			tail_n     = '0;
			served_n   = '0;
			s2_n.clear = 1'b1;
		end else if (!is_dep) begin
			// Arrival: serve at once, join the queue, or flag overflow when the queue is full.
			clock_n    = next_arr_q;
			next_arr_n = sat_time(next_arr_q, ia);
			s2_n.dt    = dt_arr;
			if (server_q) begin
				if (full) begin
					ovf_n = 1'b1;
				end else begin
					push   = 1'b1;
					tail_n = ptr_inc(tail_q);
					wc_n   = wc_q + 1'b1;
				end
			end else begin
				served_n   = served_inc;
				server_n   = 1'b1;
				pend_n     = 1'b1;
				next_dep_n = sat_time(next_arr_q, sv);
			end
		end else begin
			// Departure: go idle or start the oldest waiting customer.
			s2_n.kind = EV_DEPARTURE;
			clock_n   = next_dep_q;
			s2_n.dt   = dt_dep;
			if (wc_q == '0) begin
				server_n = 1'b0;
				pend_n   = 1'b0;
			end else begin
				s2_n.pop   = 1'b1;
				head_n     = ptr_inc(head_q);
				wc_n       = wc_q - 1'b1;
				served_n   = served_inc;
				next_dep_n = sat_time(next_dep_q, sv);
			end
		end

		s2_n.clock  = clock_n;
		s2_n.wc     = wc_n;
		s2_n.busy   = server_n;
		s2_n.served = served_n;
		s2_n.ovf    = ovf_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_q    <= '0;
			next_arr_q <= '0;
			next_dep_q <= '0;
			pend_q     <= 1'b0;
			server_q   <= 1'b0;
			ovf_q      <= 1'b0;
			wc_q       <= '0;
			head_q     <= '0;
			tail_q     <= '0;
			served_q   <= '0;
		end else if (s1_adv) begin
			clock_q    <= clock_n;
			next_arr_q <= next_arr_n;
			next_dep_q <= next_dep_n;
			pend_q     <= pend_n;
			server_q   <= server_n;
			ovf_q      <= ovf_n;
			wc_q       <= wc_n;
			head_q     <= head_n;
			tail_q     <= tail_n;
			served_q   <= served_n;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			st_s2 <= s2_n;
		end
	end

	// Stage 2: queue-length product, waiting delay sum and the stop flag.
	always_comb begin
		logic [DLY_SUM_W-1:0] d_sum;

		d_sum = DLY_SUM_W'(delay_q) + DLY_SUM_W'(st_s2.pop_diff);
		if (st_s2.clear) begin
			delay_n = '0;
		end else if (st_s2.pop) begin
			delay_n = (d_sum > DLY_SUM_W'(DELAY_MAX)) ? DELAY_MAX : d_sum[DELAY_W-1:0];
		end else begin
			delay_n = delay_q;
		end

		s3_n.kind    = st_s2.kind;
		s3_n.clock   = st_s2.clock;
		s3_n.wc      = st_s2.wc;
		s3_n.busy    = st_s2.busy;
		s3_n.served  = st_s2.served;
		s3_n.delay   = delay_n;
		s3_n.ovf     = st_s2.ovf;
		s3_n.time_up = TU_W'(st_s2.clock) >= TU_W'(stop_q);
		s3_n.clear   = st_s2.clear;
		s3_n.prod    = PROD_W'(st_s2.dt) * PROD_W'(st_s2.wc_old);
		s3_n.busy_dt = st_s2.busy_old ? st_s2.dt : {TW{1'b0}};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q <= '0;
		end else if (s2_adv) begin
			delay_q <= delay_n;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_adv) begin
			st_s3 <= s3_n;
		end
	end

	// Stage 3: saturating area accumulation and output word assembly.
	always_comb begin
		logic [AREA_SUM_W-1:0] l_sum;
		logic [BUSY_SUM_W-1:0] b_sum;

		l_sum = AREA_SUM_W'(len_area_q) + AREA_SUM_W'(st_s3.prod);
		b_sum = BUSY_SUM_W'(busy_area_q) + BUSY_SUM_W'(st_s3.busy_dt);
		if (st_s3.clear) begin
			len_area_n  = '0;
			busy_area_n = '0;
		end else begin
			len_area_n  = (l_sum > AREA_SUM_W'(AREA_MAX)) ? AREA_MAX : l_sum[AREA_W-1:0];
			busy_area_n = (b_sum > BUSY_SUM_W'(AREA_MAX)) ? AREA_MAX : b_sum[AREA_W-1:0];
		end

		out_data_n = {OUT_PAD_W'(0), st_s3.time_up, st_s3.ovf, busy_area_n, len_area_n,
			st_s3.delay, st_s3.served, st_s3.busy, QLEN_W'(st_s3.wc), NOW_W'(st_s3.clock)};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_area_q  <= '0;
			busy_area_q <= '0;
		end else if (out_load) begin
			len_area_q  <= len_area_n;
			busy_area_q <= busy_area_n;
		end
	end

	// Output register, held while the consumer stalls.
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q <= out_data_n;
			out_kind_q <= st_s3.kind;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = OUT_TUSER_W'(out_kind_q);

	// A departure is scheduled exactly while the server is busy.
	`ASSERT_ALWAYS(a_pend_matches_busy, clk, arst_n, pend_q == server_q, "departure pending without busy server")
	// Customers only wait behind a busy server.
	`ASSERT_IMPLY(a_wait_needs_busy, clk, arst_n, wc_q != '0, server_q, "customers waiting at an idle server")
	// An empty or full queue has its pointers together.
	`ASSERT_IMPLY(a_ptr_match, clk, arst_n, (wc_q == '0) || (wc_q == WC_W'(FIFO_DEPTH)), head_q == tail_q, "queue pointers disagree with count")
	// The overflow flag is sticky until a start word passes stage 1.
	`ASSERT_NEXT(a_ovf_sticky, clk, arst_n, ovf_q && !(s1_adv && (mode_s1 == MODE_START)), ovf_q, "overflow flag dropped without start")

endmodule

// ===== verif/single_server_queue_event_step_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for single_server_queue_event_step: a queue of words feeds
// a stream driver, and a monitor checks every result against a cycle-free queue model.
// Depends on ssq_pkg and the single_server_queue_event_step RTL.
module single_server_queue_event_step_test;
	import ssq_pkg::*;

	localparam int QUEUE_DEPTH = 128;
	localparam longint unsigned TIME_CAP = 64'hFFFF_FFFF;
	localparam int CYCLE_LIMIT = 400000;
	localparam int PRINT_LIMIT = 200;

	typedef enum int {
		LOAD_EVEN,
		LOAD_HEAVY,
		LOAD_LIGHT
	} load_t;

	typedef struct {
		mode_t             mode;
		logic [RAND_W-1:0] ra;
		logic [RAND_W-1:0] rs;
	} stim_word_t;

	typedef struct {
		event_kind_t        kind;
		logic [NOW_W-1:0]   now;
		logic [QLEN_W-1:0]  qlen;
		logic               busy;
		logic [COUNT_W-1:0] served;
		logic [DELAY_W-1:0] delay;
		logic [AREA_W-1:0]  qarea;
		logic [AREA_W-1:0]  barea;
		logic               ovf;
		logic               tup;
	} queue_result_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [IN_TDATA_W-1:0] s_axis_tdata;
	logic [IN_TUSER_W-1:0] s_axis_tuser;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic [OUT_TUSER_W-1:0] m_axis_tuser;

	single_server_queue_event_step uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Model copy of the configuration registers.
	logic [QLIM_W-1:0] lim_reg;
	logic [STOP_W-1:0] stop_reg;

	// Model copy of the queue state.
	logic [NOW_W-1:0] sim_clock;
	logic [NOW_W-1:0] arrival_due;
	logic [NOW_W-1:0] departure_due;
	logic departure_armed;
	logic server_busy;
	int waiting;
	logic [NOW_W-1:0] arrival_stamp [QUEUE_DEPTH];
	int head_ptr;
	int tail_ptr;
	logic [COUNT_W-1:0] served_total;
	logic [DELAY_W-1:0] delay_total;
	logic [AREA_W-1:0] length_integral;
	logic [AREA_W-1:0] busy_integral;
	logic overflow_hit;

	stim_word_t word_backlog[$];
	queue_result_t results_due[$];
	int words_loaded = 0;
	int words_taken = 0;
	int results_seen = 0;
	int departures_seen = 0;
	int overflow_results = 0;
	int late_results = 0;
	int deepest_queue = 0;
	int mismatches = 0;
	int cycle_count = 0;

	// Idle controls, set between phases.
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit no_idle = 1'b0;
	int send_gap = 0;
	int stall_left = 0;
	logic word_taken;

	function automatic longint unsigned capped_sum(input longint unsigned a,
			input longint unsigned b, input longint unsigned cap);
		if (a > cap) a = cap;
		if (b > cap - a) return cap;
		return a + b;
	endfunction

	// Interarrival time: five units per table edge passed, plus five.
	function automatic longint unsigned interarrival(input logic [RAND_W-1:0] k);
		int n;
		n = int'(k > 16'd3276) + int'(k > 16'd6553) + int'(k > 16'd13107)
			+ int'(k > 16'd19660) + int'(k > 16'd39321) + int'(k > 16'd52428)
			+ int'(k > 16'd62259);
		return 5 * (n + 1);
	endfunction

	// Service time: ten units per table edge passed, plus ten.
	function automatic longint unsigned service_time(input logic [RAND_W-1:0] k);
		int n;
		n = int'(k > 16'd9830) + int'(k > 16'd26214) + int'(k > 16'd52428);
		return 10 * (n + 1);
	endfunction

	function automatic void clear_queue_state();
		sim_clock = '0;
		arrival_due = '0;
		departure_due = '0;
		departure_armed = 1'b0;
		server_busy = 1'b0;
		waiting = 0;
		head_ptr = 0;
		tail_ptr = 0;
		served_total = '0;
		delay_total = '0;
		length_integral = '0;
		busy_integral = '0;
		overflow_hit = 1'b0;
	endfunction

	// One event of the queue: returns the state snapshot the block should report.
	function automatic queue_result_t queue_event(input mode_t mode,
			input logic [RAND_W-1:0] ra, input logic [RAND_W-1:0] rs);
		queue_result_t r;
		logic take_dep;
		longint unsigned ev_t;
		longint unsigned dt;
		longint unsigned cap;
		longint unsigned stamp;
		r.kind = EV_ARRIVAL;
		if (mode == MODE_START) begin
			clear_queue_state();
			arrival_due = NOW_W'(interarrival(ra));
		end else begin
			take_dep = departure_armed && (departure_due <= arrival_due);
			ev_t = take_dep ? departure_due : arrival_due;
			dt = (ev_t >= sim_clock) ? ev_t - sim_clock : 0;
			sim_clock = NOW_W'(ev_t);
			if (dt != 0 && waiting != 0) begin
				length_integral = AREA_W'(capped_sum(length_integral,
					dt * longint'(waiting), AREA_MAX));
			end
			if (server_busy) begin
				busy_integral = AREA_W'(capped_sum(busy_integral, dt, AREA_MAX));
			end
			if (!take_dep) begin
				arrival_due = NOW_W'(capped_sum(sim_clock, interarrival(ra), TIME_CAP));
				if (server_busy) begin
					cap = (lim_reg > QUEUE_DEPTH) ? QUEUE_DEPTH : lim_reg;
					if (waiting >= cap) begin
						overflow_hit = 1'b1;
					end else begin
						arrival_stamp[tail_ptr] = sim_clock;
						tail_ptr = (tail_ptr + 1) % QUEUE_DEPTH;
						waiting++;
					end
				end else begin
					served_total = COUNT_W'(capped_sum(served_total, 1, COUNT_MAX));
					server_busy = 1'b1;
					departure_armed = 1'b1;
					departure_due = NOW_W'(capped_sum(sim_clock, service_time(rs), TIME_CAP));
				end
			end else begin
				r.kind = EV_DEPARTURE;
				if (waiting == 0) begin
					server_busy = 1'b0;
					departure_armed = 1'b0;
				end else begin
					// The oldest waiting customer enters service.
					stamp = arrival_stamp[head_ptr];
					head_ptr = (head_ptr + 1) % QUEUE_DEPTH;
					waiting--;
					delay_total = DELAY_W'(capped_sum(delay_total,
						(sim_clock >= stamp) ? sim_clock - stamp : 0, DELAY_MAX));
					served_total = COUNT_W'(capped_sum(served_total, 1, COUNT_MAX));
					departure_due = NOW_W'(capped_sum(sim_clock, service_time(rs), TIME_CAP));
				end
			end
		end
		r.now = sim_clock;
		r.qlen = QLEN_W'(waiting);
		r.busy = server_busy;
		r.served = served_total;
		r.delay = delay_total;
		r.qarea = length_integral;
		r.barea = busy_integral;
		r.ovf = overflow_hit;
		r.tup = (sim_clock >= stop_reg);
		return r;
	endfunction

	task automatic check_field(input string label, input longint unsigned want,
			input longint unsigned got);
		if (want != got) begin
			if (mismatches < PRINT_LIMIT) begin
				$display("%0t: %s mismatch, expected %0d, got %0d", $time, label, want, got);
			end
			mismatches++;
		end
	endtask

	// Input side: present the next word once the previous one was taken.
	always @(negedge clk) begin
		stim_word_t w;
		if (arst_n && (!s_axis_tvalid || word_taken)) begin
			if (send_gap > 0) begin
				send_gap <= send_gap - 1;
				s_axis_tvalid <= 1'b0;
			end else if (word_backlog.size() != 0) begin
				w = word_backlog.pop_front();
				s_axis_tdata <= {w.rs, w.ra};
				s_axis_tuser <= w.mode;
				s_axis_tvalid <= 1'b1;
				if (!no_idle && $urandom_range(99) < send_idle_pct) begin
					send_gap <= $urandom_range(6, 1);
				end
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// Output side: ready, but for random stall bursts.
	always @(negedge clk) begin
		if (arst_n) begin
			if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				m_axis_tready <= 1'b0;
			end else if (!no_idle && $urandom_range(99) < recv_stall_pct) begin
				stall_left <= $urandom_range(5, 0);
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// Check each result word, then predict for each accepted input word.
	always @(posedge clk) begin
		queue_result_t want;
		logic [OUT_TDATA_W-1:0] d;
		word_taken <= s_axis_tvalid && s_axis_tready;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			d = m_axis_tdata;
			if (results_due.size() == 0) begin
				if (mismatches < PRINT_LIMIT) begin
					$display("%0t: result word with nothing expected, data %h", $time, d);
				end
				mismatches++;
			end else begin
				want = results_due.pop_front();
				check_field("event_kind", want.kind, m_axis_tuser[0]);
				check_field("now_time", want.now, d[31:0]);
				check_field("queue_length", want.qlen, d[39:32]);
				check_field("busy_res", want.busy, d[40]);
				check_field("delayed_customers", want.served, d[72:41]);
				check_field("total_delay", want.delay, d[112:73]);
				check_field("queue_area", want.qarea, d[160:113]);
				check_field("busy_area", want.barea, d[208:161]);
				check_field("overflow", want.ovf, d[209]);
				check_field("time_up", want.tup, d[210]);
				results_seen++;
				if (want.kind == EV_DEPARTURE) departures_seen++;
				if (want.ovf) overflow_results++;
				if (want.tup) late_results++;
				if (want.qlen > deepest_queue) deepest_queue = want.qlen;
			end
		end
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			results_due.push_back(queue_event(mode_t'(s_axis_tuser[0]),
				s_axis_tdata[RAND_W-1:0], s_axis_tdata[IN_TDATA_W-1:RAND_W]));
			words_taken++;
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("%0t: run timed out with %0d results outstanding", $time,
				results_due.size());
			$display("FAIL");
			$finish;
		end
	end

	task automatic push_word(input mode_t mode, input logic [RAND_W-1:0] ra,
			input logic [RAND_W-1:0] rs);
		stim_word_t w;
		w.mode = mode;
		w.ra = ra;
		w.rs = rs;
		word_backlog.push_back(w);
		words_loaded++;
	endtask

	// Hold until every loaded word is taken and every result has arrived.
	task automatic wait_quiet();
		while (words_taken != words_loaded || results_due.size() != 0) begin
			@(negedge clk);
		end
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		if (idx == REG_QUEUE_LIMIT) lim_reg = val[QLIM_W-1:0];
		else stop_reg = val[STOP_W-1:0];
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// A start word followed by steps whose draws lean toward the given load.
	task automatic load_phase(input load_t load, input int steps, input bit noisy);
		logic [RAND_W-1:0] ra;
		logic [RAND_W-1:0] rs;
		mode_t m;
		int n;
		push_word(MODE_START, RAND_W'($urandom_range(65535)), RAND_W'($urandom_range(65535)));
		for (n = 0; n < steps; n++) begin
			case (load)
				LOAD_HEAVY: begin
					ra = RAND_W'($urandom_range(13107));
					rs = RAND_W'($urandom_range(65535, 26215));
				end
				LOAD_LIGHT: begin
					ra = RAND_W'($urandom_range(65535, 39322));
					rs = RAND_W'($urandom_range(9830));
				end
				default: begin
					ra = RAND_W'($urandom_range(65535));
					rs = RAND_W'($urandom_range(65535));
				end
			endcase
			m = (noisy && $urandom_range(99) < 2) ? MODE_START : MODE_STEP;
			push_word(m, ra, rs);
		end
	endtask

	task automatic run_phase(input load_t load, input int steps, input bit noisy,
			input logic [QLIM_W-1:0] qlim, input logic [STOP_W-1:0] stop, input int idle_pct);
		wait_quiet();
		write_reg(REG_QUEUE_LIMIT, CFG_DATA_W'(qlim));
		write_reg(REG_STOP_TIME, stop);
		send_idle_pct = idle_pct;
		recv_stall_pct = idle_pct;
		load_phase(load, steps, noisy);
	endtask

	initial begin
		int p;
		logic [QLIM_W-1:0] qlim;
		logic [STOP_W-1:0] stop;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_QUEUE_LIMIT;
		cfg_wdata = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = MODE_START;
		m_axis_tready = 1'b0;
		word_taken = 1'b0;
		lim_reg = QLIMIT_RESET;
		stop_reg = STOP_RESET;
		clear_queue_state();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Steps straight out of reset, then a run that walks the table edges
		// and reaches a tie between arrival and departure.
		send_idle_pct = 30;
		recv_stall_pct = 30;
		push_word(MODE_STEP, 16'd0, 16'd0);
		push_word(MODE_STEP, 16'd65535, 16'd65535);
		push_word(MODE_START, 16'd65535, 16'd65535);
		push_word(MODE_STEP, 16'd3276, 16'd65535);
		push_word(MODE_STEP, 16'd3277, 16'd9830);
		push_word(MODE_STEP, 16'd62259, 16'd9831);
		push_word(MODE_STEP, 16'd62260, 16'd52428);
		push_word(MODE_STEP, 16'd19660, 16'd52429);
		push_word(MODE_STEP, 16'd39321, 16'd26214);
		push_word(MODE_STEP, 16'd6553, 16'd26215);
		push_word(MODE_STEP, 16'd13107, 16'd0);
		push_word(MODE_STEP, 16'd52428, 16'd65535);

		// Queue limit of one: the second waiting customer is dropped.
		wait_quiet();
		write_reg(REG_QUEUE_LIMIT, CFG_DATA_W'(1));
		write_reg(REG_STOP_TIME, '0);
		push_word(MODE_START, 16'd0, 16'd0);
		repeat (5) push_word(MODE_STEP, 16'd0, 16'd65535);

		// A zero limit drops every arrival that finds the server busy.
		wait_quiet();
		write_reg(REG_QUEUE_LIMIT, CFG_DATA_W'(0));
		write_reg(REG_STOP_TIME, '1);
		push_word(MODE_START, 16'd0, 16'd65535);
		repeat (4) push_word(MODE_STEP, 16'd0, 16'd65535);

		// Full queue depth under heavy load, so the arrival-time queue wraps.
		run_phase(LOAD_HEAVY, 400, 1'b0, 8'd128, '1, 20);
		run_phase(LOAD_EVEN, 300, 1'b1, QLIM_W'($urandom_range(128, 1)),
			STOP_W'($urandom_range(4000)), 40);
		run_phase(LOAD_LIGHT, 200, 1'b0, 8'd1, '0, 0);
		// A limit past the queue depth is held to the depth.
		run_phase(LOAD_HEAVY, 250, 1'b0, 8'd255, STOP_W'($urandom_range(4000)), 10);

		for (p = 0; p < 3; p++) begin
			case ($urandom_range(2))
				0: qlim = 8'd1;
				1: qlim = 8'd128;
				default: qlim = QLIM_W'($urandom_range(128, 1));
			endcase
			case ($urandom_range(3))
				0: stop = '0;
				1: stop = '1;
				2: stop = STOP_RESET;
				default: stop = STOP_W'($urandom_range(4000));
			endcase
			run_phase(load_t'($urandom_range(2)), 250, 1'b1, qlim, stop,
				(p == 1) ? 0 : 25);
		end

		// Closing stretch with both sides running at full rate.
		wait_quiet();
		no_idle = 1'b1;
		run_phase(LOAD_EVEN, 200, 1'b0, QLIMIT_RESET, STOP_RESET, 0);

		wait_quiet();
		repeat (8) @(posedge clk);
		$display("Checked %0d results from %0d words: %0d departures, deepest queue %0d.",
			results_seen, words_taken, departures_seen, deepest_queue);
		$display("Results with overflow flagged: %0d, past stop time: %0d, mismatches: %0d.",
			overflow_results, late_results, mismatches);
		if (mismatches == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+design
design/ssq_pkg.sv
design/ssq_ram.sv
design/single_server_queue_event_step.sv
verif/single_server_queue_event_step_test.sv
